@@ rtl/adjacent_duplicate_line_filter_core_macros.svh @@
// Assertion helpers used by the filter's group queue module.
`ifndef ADJACENT_DUPLICATE_LINE_FILTER_CORE_MACROS_SVH
`define ADJACENT_DUPLICATE_LINE_FILTER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ADLF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ADLF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/adlf_pkg.sv @@
`timescale 1ns / 1ps
package adlf_pkg;

    // Input commands.
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_EOL   = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // Output modes.
    localparam logic [1:0] MODE_ALL      = 2'd0;
    localparam logic [1:0] MODE_REPEATED = 2'd1;
    localparam logic [1:0] MODE_UNIQUE   = 2'd2;
    localparam logic [1:0] MODE_ALL_REP  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_OUTPUT_MODE = 3'd0;
    localparam logic [2:0] REG_WITH_COUNT  = 3'd1;
    localparam logic [2:0] REG_SKIP_FIELDS = 3'd2;
    localparam logic [2:0] REG_SKIP_CHARS  = 3'd3;
    localparam logic [2:0] REG_LIMIT       = 3'd4;
    localparam logic [2:0] REG_FOLD_CASE   = 3'd5;

    localparam logic [7:0]  CHAR_LF  = 8'h0A;
    localparam logic [31:0] SAT_MAX  = 32'hFFFF_FFFF;
    localparam int          QDEPTH   = 4;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_FIELD,
        PH_GAP,
        PH_KEY
    } t_phase;

    typedef struct packed {
        logic [1:0]  output_mode;
        logic        with_count;
        logic [7:0]  field_skip;
        logic [13:0] char_skip;
        logic [13:0] limit;
        logic        fold_case;
    } t_cfg;

    // One closed group on its way to the result stage.
    typedef struct packed {
        logic [31:0] size;
        logic [31:0] start;
        logic        ovf;
        logic        last;
    } t_grp;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
        return (en && c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

endpackage

@@ rtl/adlf_ram.sv @@
`timescale 1ns / 1ps
module adlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/adlf_front.sv @@
`timescale 1ns / 1ps
module adlf_front import adlf_pkg::*; #(
    parameter int KEY_BYTES = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [1:0] i_command,
    input  logic [7:0] i_line_byte,
    output logic       o_push_a,
    output t_grp       o_rec_a,
    output logic       o_push_b,
    output t_grp       o_rec_b
);

    localparam int KW = $clog2(KEY_BYTES + 1);
    localparam int AW = $clog2(2 * KEY_BYTES);

    // Line parsing and group state.
    logic          r_act, n_act;
    logic          r_have, n_have;
    logic          r_open, n_open;
    logic [31:0]   r_gsize, n_gsize;
    logic [31:0]   r_gstart, n_gstart;
    logic [31:0]   r_lcnt, n_lcnt;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_fpass, n_fpass;
    logic [13:0]   r_cpass, n_cpass;
    logic [KW-1:0] r_kpos, n_kpos;
    logic          r_mis, n_mis;
    logic          r_ovf, n_ovf;
    logic          r_govf, n_govf;
    logic [KW-1:0] r_klen [2];
    logic [KW-1:0] n_klen [2];

    // Compare stage: byte waiting for the stored key byte.
    logic          r_cmp_valid, n_cmp_valid;
    logic [7:0]    r_cmp_byte, n_cmp_byte;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    adlf_ram #(.WIDTH(8), .DEPTH(2 * KEY_BYTES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next-state logic for one item.
    always_comb begin
        logic          mis_eff, differs, go, fin, take, flush;
        logic          h, gov;
        logic [31:0]   gs, gst;
        logic [7:0]    fp, c2;
        logic [AW-1:0] pos;
        mis_eff     = r_mis | (r_cmp_valid && (ram_rdata != r_cmp_byte));
        n_act       = r_act;
        n_have      = r_have;
        n_open      = r_open;
        n_gsize     = r_gsize;
        n_gstart    = r_gstart;
        n_lcnt      = r_lcnt;
        n_phase     = r_phase;
        n_fpass     = r_fpass;
        n_cpass     = r_cpass;
        n_kpos      = r_kpos;
        n_mis       = mis_eff;
        n_ovf       = r_ovf;
        n_govf      = r_govf;
        n_klen      = r_klen;
        n_cmp_valid = 1'b0;
        n_cmp_byte  = r_cmp_byte;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;
        o_push_a    = 1'b0;
        o_push_b    = 1'b0;
        o_rec_a     = '{size: r_gsize, start: r_gstart, ovf: r_govf, last: 1'b1};
        o_rec_b     = '0;
        go          = 1'b0;
        differs     = mis_eff || (r_kpos != r_klen[r_act]);
        take  = i_accept && (i_command == CMD_BYTE) && (i_line_byte != CHAR_LF);
        flush = i_accept && (i_command == CMD_FLUSH);
        fin   = i_accept && (((i_command == CMD_BYTE) && (i_line_byte == CHAR_LF))
                || (i_command == CMD_EOL) || (flush && r_open));
        c2    = fold_char(i_line_byte, i_cfg.fold_case);
        pos   = AW'(r_kpos);
        fp    = r_fpass + {7'd0, (r_fpass != 8'hFF)};

        // A plain byte moves through the field and char skips into the key.
        if (take) begin
            n_open = 1'b1;
            case (r_phase)
                PH_LEAD: begin
                    if (r_fpass < i_cfg.field_skip) begin
                        if (!is_blank(i_line_byte)) begin
                            n_phase = PH_FIELD;
                        end
                    end else begin
                        n_phase = PH_KEY;
                        go      = 1'b1;
                    end
                end
                PH_FIELD: begin
                    if (is_blank(i_line_byte)) begin
                        n_fpass = fp;
                        n_phase = (fp >= i_cfg.field_skip) ? PH_GAP : PH_LEAD;
                    end
                end
                PH_GAP: begin
                    if (!is_blank(i_line_byte)) begin
                        n_phase = PH_KEY;
                        go      = 1'b1;
                    end
                end
                default: begin
                    go = 1'b1;
                end
            endcase
            if (go) begin
                if (r_cpass < i_cfg.char_skip) begin
                    n_cpass = r_cpass + 14'd1;
                end else if (i_cfg.limit != 14'd0 && 32'(r_kpos) >= 32'(i_cfg.limit)) begin
                    n_cpass = r_cpass;
                end else if (32'(r_kpos) >= 32'(KEY_BYTES)) begin
                    n_ovf = 1'b1;
                end else begin
                    if (r_kpos >= r_klen[r_act]) begin
                        n_mis = 1'b1;
                    end else begin
                        n_cmp_valid = 1'b1;
                        n_cmp_byte  = c2;
                        ram_raddr   = r_act ? pos + AW'(KEY_BYTES) : pos;
                    end
                    ram_we    = 1'b1;
                    ram_wdata = c2;
                    ram_waddr = r_act ? pos : pos + AW'(KEY_BYTES);
                    n_kpos    = r_kpos + KW'(1);
                end
            end
        end

        // End of line: join the group or close it and start a new one.
        h   = r_have;
        gs  = r_gsize;
        gst = r_gstart;
        gov = r_govf;
        if (fin) begin
            if (r_have && !differs) begin
                gs  = (r_gsize == SAT_MAX) ? r_gsize : r_gsize + 32'd1;
                gov = r_govf | r_ovf;
            end else begin
                o_push_a          = r_have;
                n_act             = ~r_act;
                n_klen[~r_act]    = r_kpos;
                h                 = 1'b1;
                gs                = 32'd1;
                gst               = r_lcnt;
                gov               = r_ovf;
            end
            n_have   = h;
            n_gsize  = gs;
            n_gstart = gst;
            n_govf   = gov;
            n_lcnt   = r_lcnt + 32'd1;
        end
        if (fin || flush) begin
            n_open  = 1'b0;
            n_phase = PH_LEAD;
            n_fpass = '0;
            n_cpass = '0;
            n_kpos  = '0;
            n_mis   = 1'b0;
            n_ovf   = 1'b0;
        end

        // End of stream: report the open group and start over.
        if (flush) begin
            o_push_b     = h;
            o_rec_b      = '{size: gs, start: gst, ovf: gov, last: 1'b1};
            o_rec_a.last = !h;
            n_have       = 1'b0;
            n_gsize      = '0;
            n_govf       = 1'b0;
            n_lcnt       = '0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_have      <= 1'b0;
            r_open      <= 1'b0;
            r_gsize     <= '0;
            r_gstart    <= '0;
            r_lcnt      <= '0;
            r_phase     <= PH_LEAD;
            r_fpass     <= '0;
            r_cpass     <= '0;
            r_kpos      <= '0;
            r_mis       <= 1'b0;
            r_ovf       <= 1'b0;
            r_govf      <= 1'b0;
            r_klen[0]   <= '0;
            r_klen[1]   <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_act       <= n_act;
            r_have      <= n_have;
            r_open      <= n_open;
            r_gsize     <= n_gsize;
            r_gstart    <= n_gstart;
            r_lcnt      <= n_lcnt;
            r_phase     <= n_phase;
            r_fpass     <= n_fpass;
            r_cpass     <= n_cpass;
            r_kpos      <= n_kpos;
            r_mis       <= n_mis;
            r_ovf       <= n_ovf;
            r_govf      <= n_govf;
            r_klen      <= n_klen;
            r_cmp_valid <= n_cmp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_byte <= n_cmp_byte;
    end

endmodule

@@ rtl/adlf_queue.sv @@
`timescale 1ns / 1ps
`include "adjacent_duplicate_line_filter_core_macros.svh"
module adlf_queue import adlf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_a,
    input  t_grp i_rec_a,
    input  logic i_push_b,
    input  t_grp i_rec_b,
    input  logic i_pop,
    output t_grp o_head,
    output logic o_nonempty,
    output logic o_room_two
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_grp          r_mem [QDEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] wptr_b;

    assign wptr_b     = i_push_a ? r_wptr + PW'(1) : r_wptr;
    assign o_head     = r_mem[r_rptr];
    assign o_nonempty = (r_count != '0);
    assign o_room_two = (r_count <= CW'(QDEPTH - 2));

    // Up to two items enter per cycle, in order.
    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wptr] <= i_rec_a;
        end
        if (i_push_b) begin
            r_mem[wptr_b] <= i_rec_b;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PW'(i_push_a) + PW'(i_push_b);
            r_rptr  <= r_rptr + PW'(i_pop);
            r_count <= r_count + CW'(i_push_a) + CW'(i_push_b) - CW'(i_pop);
        end
    end

    `ADLF_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")
    `ADLF_ASSERT_IMP(a_push_room, i_clk, i_rst_n, i_push_a && i_push_b, r_count <= CW'(QDEPTH - 2), "queue overrun")
    `ADLF_ASSERT_NXT(a_pop_count, i_clk, i_rst_n, i_pop && !i_push_a && !i_push_b, r_count == $past(r_count) - CW'(1), "count did not drop on pop")

endmodule

@@ rtl/adlf_back.sv @@
`timescale 1ns / 1ps
module adlf_back import adlf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_grp        i_head,
    input  logic        i_nonempty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_copies,
    output logic [31:0] o_group_count,
    output logic        o_show_count,
    output logic [31:0] o_first_line_index,
    output logic        o_key_overflow,
    output logic        o_last_of_run
);

    logic        r_valid;
    logic [31:0] r_copies, r_count, r_index;
    logic        r_show, r_ovf, r_last;
    logic [31:0] n_copies;
    logic        multi;

    assign o_pop = i_nonempty && (!r_valid || !i_out_stall);
    assign multi = (i_head.size > 32'd1);

    // Copies to print under the selected mode.
    always_comb begin
        case (i_cfg.output_mode)
            MODE_ALL:      n_copies = 32'd1;
            MODE_REPEATED: n_copies = {31'd0, multi};
            MODE_UNIQUE:   n_copies = {31'd0, i_head.size == 32'd1};
            MODE_ALL_REP:  n_copies = multi ? i_head.size : 32'd0;
            default:       n_copies = 32'd0;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_out_stall) begin
            r_valid <= i_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_copies <= n_copies;
            r_count  <= i_head.size;
            r_show   <= i_cfg.with_count && (i_cfg.output_mode != MODE_ALL_REP);
            r_index  <= i_head.start;
            r_ovf    <= i_head.ovf;
            r_last   <= i_head.last;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_copies           = r_copies;
    assign o_group_count      = r_count;
    assign o_show_count       = r_show;
    assign o_first_line_index = r_index;
    assign o_key_overflow     = r_ovf;
    assign o_last_of_run      = r_last;

endmodule

@@ rtl/adjacent_duplicate_line_filter_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_command, i_line_byte
// result    out        o_out_valid / i_out_stall copies, counts, index, flags
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item is taken per cycle while the input is not stalled; the key store read
// and compare of a byte finish in the next cycle, overlapped with the next item.
// A result leaves through a four-entry group queue and the output register.
// Reset is synchronous and clears all control state; no clearing pass.
// The input stalls only while the group queue has fewer than two free slots.
module adjacent_duplicate_line_filter_core import adlf_pkg::*; #(
    parameter int KEY_BYTES = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_line_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_copies,
    output logic [31:0] o_group_count,
    output logic        o_show_count,
    output logic [31:0] o_first_line_index,
    output logic        o_key_overflow,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    t_cfg r_cfg;
    logic accept, push_a, push_b, pop, nonempty, room_two;
    t_grp rec_a, rec_b, head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !room_two;
    assign accept      = i_in_valid && room_two;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OUTPUT_MODE: r_cfg.output_mode <= i_cfg_data[1:0];
                REG_WITH_COUNT:  r_cfg.with_count  <= i_cfg_data[0];
                REG_SKIP_FIELDS: r_cfg.field_skip  <= i_cfg_data[7:0];
                REG_SKIP_CHARS:  r_cfg.char_skip   <= i_cfg_data;
                REG_LIMIT:       r_cfg.limit       <= i_cfg_data;
                REG_FOLD_CASE:   r_cfg.fold_case   <= i_cfg_data[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    adlf_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_line_byte (i_line_byte),
        .o_push_a    (push_a),
        .o_rec_a     (rec_a),
        .o_push_b    (push_b),
        .o_rec_b     (rec_b)
    );

    adlf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_a   (push_a),
        .i_rec_a    (rec_a),
        .i_push_b   (push_b),
        .i_rec_b    (rec_b),
        .i_pop      (pop),
        .o_head     (head),
        .o_nonempty (nonempty),
        .o_room_two (room_two)
    );

    adlf_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_head             (head),
        .i_nonempty         (nonempty),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_copies           (o_copies),
        .o_group_count      (o_group_count),
        .o_show_count       (o_show_count),
        .o_first_line_index (o_first_line_index),
        .o_key_overflow     (o_key_overflow),
        .o_last_of_run      (o_last_of_run)
    );

endmodule
